// File: rtl/bb3_pkg.sv
// ----------------------------------------------------------------------------
// bb3_pkg
// Shared types, register indexes and arithmetic helpers of the 3x3 box blur.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bb3_pkg;

    localparam int CH_W       = 8;                 // bits per color channel
    localparam int N_CH       = 3;                 // red, green, blue
    localparam int PIX_W      = CH_W * N_CH;       // packed pixel, red in low byte
    localparam int N_TAPS     = 9;
    localparam int SUM_W      = 12;                // nine 8-bit samples: max 2295

    // configuration port
    localparam int CFG_IDX_W    = 1;
    localparam int WIDTH_REG_W  = 12;
    localparam int HEIGHT_REG_W = 13;
    localparam int CFG_DATA_W   = 13;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [WIDTH_REG_W-1:0]  IMAGE_WIDTH_RST  = 12'd640;
    localparam logic [HEIGHT_REG_W-1:0] IMAGE_HEIGHT_RST = 13'd480;

    localparam int MIN_DIM = 3;

    // floor(x / 9) = (x * 7282) >> 16, exact for x < 32768
    localparam int RECIP_W = 13;
    localparam logic [RECIP_W-1:0] DIV9_RECIP = 13'd7282;
    localparam int DIV9_SHIFT = 16;

    typedef logic [PIX_W-1:0] t_pixel;

    // per-transaction decisions made at the input, carried down the pipe
    typedef struct packed {
        logic keep;         // item enters the pipe (pixel, or flush with work)
        logic is_pixel;     // pixel item: writes line store, shifts window
        logic emit;         // produces a result
        logic blur;         // result is the 3x3 average
        logic flush_upper;  // flush result comes from the upper line
        logic frame_end;    // result is the last pixel of the frame
    } t_item_ctl;

    function automatic logic [CH_W-1:0] div9(input logic [SUM_W-1:0] x);
        logic [SUM_W+RECIP_W-1:0] prod;
        prod = {{RECIP_W{1'b0}}, x} * {{SUM_W{1'b0}}, DIV9_RECIP};
        return prod[DIV9_SHIFT +: CH_W];
    endfunction

endpackage

// File: rtl/bb3_ctrl.sv
// ----------------------------------------------------------------------------
// bb3_ctrl
// Geometry registers, position counters and pending count; decides per item
// where the line store is read and what the result will be.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bb3_ctrl import bb3_pkg::*; #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096,
    localparam int CW = $clog2(MAX_WIDTH)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_accept,
    input  logic                  i_is_flush,
    output t_item_ctl             o_ctl,
    output logic [CW-1:0]         o_addr
);

    localparam int PW = $clog2(MAX_WIDTH + 3);   // w, w+1, col+2
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int HW = $clog2(MAX_HEIGHT + 3);

    logic [WIDTH_REG_W-1:0]  r_image_width;
    logic [HEIGHT_REG_W-1:0] r_image_height;
    logic [CW-1:0]           r_in_col,  n_in_col;
    logic [CW-1:0]           r_out_col, n_out_col;
    logic [RW-1:0]           r_out_row, n_out_row;
    logic [PW-1:0]           r_pending, n_pending;

    logic [31:0]   w_tmp, h_tmp;
    logic [PW-1:0] eff_w, w_full, ic_x, oc_x, pend_d, dd;
    logic [HW-1:0] eff_h, or_x;
    logic [PW:0]   t_addr;
    logic          emit, blur, frame_end, flush_upper, has_pending;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= IMAGE_WIDTH_RST;
            r_image_height <= IMAGE_HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_IMAGE_WIDTH:  r_image_width  <= i_cfg_wdata[WIDTH_REG_W-1:0];
                REG_IMAGE_HEIGHT: r_image_height <= i_cfg_wdata[HEIGHT_REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        // clamp geometry to the supported range
        w_tmp = 32'(r_image_width);
        if (w_tmp < 32'(MIN_DIM))   w_tmp = 32'(MIN_DIM);
        if (w_tmp > 32'(MAX_WIDTH)) w_tmp = 32'(MAX_WIDTH);
        h_tmp = 32'(r_image_height);
        if (h_tmp < 32'(MIN_DIM))    h_tmp = 32'(MIN_DIM);
        if (h_tmp > 32'(MAX_HEIGHT)) h_tmp = 32'(MAX_HEIGHT);
        eff_w  = w_tmp[PW-1:0];
        eff_h  = h_tmp[HW-1:0];
        w_full = eff_w + PW'(1);

        ic_x = PW'(r_in_col);
        oc_x = PW'(r_out_col);
        or_x = HW'(r_out_row);

        has_pending = (r_pending != '0);

        // flush source: oldest pending pixel, (in_col - depth) mod width
        pend_d      = (r_pending > w_full) ? w_full : r_pending;
        flush_upper = (pend_d == w_full);
        dd          = flush_upper ? PW'(1) : pend_d;
        t_addr      = {1'b0, ic_x} - {1'b0, dd};
        if (t_addr[PW]) t_addr = t_addr + {1'b0, eff_w};

        emit      = i_is_flush ? has_pending : (r_pending >= w_full);
        blur      = (or_x >= HW'(1)) && ((or_x + HW'(2)) <= eff_h) &&
                    (oc_x >= PW'(1)) && ((oc_x + PW'(2)) <= eff_w);
        frame_end = (or_x == (eff_h - HW'(1))) && (oc_x == (eff_w - PW'(1)));

        o_ctl.keep        = !i_is_flush || has_pending;
        o_ctl.is_pixel    = !i_is_flush;
        o_ctl.emit        = emit;
        o_ctl.blur        = blur && emit && !i_is_flush;
        o_ctl.flush_upper = flush_upper && i_is_flush;
        o_ctl.frame_end   = frame_end;
        o_addr            = i_is_flush ? t_addr[CW-1:0] : r_in_col;

        n_pending = r_pending;
        n_in_col  = r_in_col;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (i_accept) begin
            if (i_is_flush) begin
                if (has_pending) n_pending = pend_d - PW'(1);
            end else begin
                n_pending = emit ? w_full : (r_pending + PW'(1));
                n_in_col  = ((ic_x + PW'(1)) >= eff_w) ? '0 : (r_in_col + CW'(1));
            end
            if (emit) begin
                if ((oc_x + PW'(1)) >= eff_w) begin
                    n_out_col = '0;
                    n_out_row = ((or_x + HW'(1)) >= eff_h) ? '0 : (r_out_row + RW'(1));
                end else begin
                    n_out_col = r_out_col + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_pending <= '0;
        end else begin
            r_in_col  <= n_in_col;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            r_pending <= n_pending;
        end
    end

`ifndef SYNTH
    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_accept && !i_cfg_we) |-> (r_pending <= w_full))
        else $error("pending count above row length plus one");

    a_in_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_accept && !i_is_flush && !i_cfg_we) |-> (PW'(r_in_col) < eff_w))
        else $error("input column out of row after pixel");

    a_out_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_accept && emit && !i_cfg_we) |-> (PW'(r_out_col) < eff_w))
        else $error("output column out of row after result");
`endif

endmodule

// File: rtl/bb3_line_mem.sv
// ----------------------------------------------------------------------------
// bb3_line_mem
// Line store pair (upper and middle row in one word), one write and one
// registered read per cycle, write-first on an address collision.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bb3_line_mem #(
    parameter int DEPTH  = 2048,
    parameter int DATA_W = 48,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) mem[i_waddr] <= i_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            if (i_we && (i_waddr == i_raddr)) r_rdata <= i_wdata;
            else                              r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/bb3_datapath.sv
// ----------------------------------------------------------------------------
// bb3_datapath
// Input stage, line store, 3x3 window, nine-tap average and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bb3_datapath import bb3_pkg::*; #(
    parameter int MAX_WIDTH = 2048,
    localparam int CW = $clog2(MAX_WIDTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    output logic          o_s_ready,
    input  t_pixel        i_s_data,
    input  t_item_ctl     i_ctl,
    input  logic [CW-1:0] i_addr,
    output logic          o_m_valid,
    input  logic          i_m_ready,
    output t_pixel        o_m_data,
    output logic          o_m_last
);

    logic          r_s1_valid;
    t_item_ctl     r_s1_ctl;
    t_pixel        r_s1_px;
    logic [CW-1:0] r_s1_addr;

    t_pixel        r_win [6];
    logic          r_m_valid;
    t_pixel        r_m_data;
    logic          r_m_last;

    logic [2*PIX_W-1:0] mem_q;
    t_pixel             up, mid, blur_pix, res;
    t_pixel             taps [N_TAPS];
    logic [SUM_W-1:0]   sum_ch [N_CH];
    logic               out_free, s1_adv, mem_we;

    assign up  = mem_q[2*PIX_W-1:PIX_W];
    assign mid = mem_q[PIX_W-1:0];

    assign out_free  = !r_m_valid || i_m_ready;
    assign s1_adv    = r_s1_valid && (!r_s1_ctl.emit || out_free);
    assign o_s_ready = !r_s1_valid || s1_adv;
    assign mem_we    = s1_adv && r_s1_ctl.is_pixel;

    // upper <= old middle, middle <= new pixel, at the item's column
    bb3_line_mem #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (2*PIX_W)
    ) u_line_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_s1_addr),
        .i_wdata ({mid, r_s1_px}),
        .i_re    (i_accept),
        .i_raddr (i_addr),
        .o_rdata (mem_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)       r_s1_valid <= 1'b0;
        else if (o_s_ready) r_s1_valid <= i_accept && i_ctl.keep;
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_ctl  <= i_ctl;
            r_s1_px   <= i_s_data;
            r_s1_addr <= i_addr;
        end
    end

    always_comb begin
        for (int k = 0; k < 6; k++) taps[k] = r_win[k];
        taps[6] = up;
        taps[7] = mid;
        taps[8] = r_s1_px;
        for (int c = 0; c < N_CH; c++) begin
            sum_ch[c] = '0;
            for (int k = 0; k < N_TAPS; k++)
                sum_ch[c] = sum_ch[c] + SUM_W'(taps[k][c*CH_W +: CH_W]);
            blur_pix[c*CH_W +: CH_W] = div9(sum_ch[c]);
        end
    end

    always_comb begin
        if (r_s1_ctl.is_pixel) res = r_s1_ctl.blur ? blur_pix : r_win[4];
        else                   res = r_s1_ctl.flush_upper ? up : mid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) r_win[k] <= '0;
        end else if (mem_we) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= up;
            r_win[4] <= mid;
            r_win[5] <= r_s1_px;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)                        r_m_valid <= 1'b0;
        else if (s1_adv && r_s1_ctl.emit)    r_m_valid <= 1'b1;
        else if (i_m_ready)                  r_m_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_ctl.emit) begin
            r_m_data <= res;
            r_m_last <= r_s1_ctl.frame_end;
        end
    end

    assign o_m_valid = r_m_valid;
    assign o_m_data  = r_m_data;
    assign o_m_last  = r_m_last;

`ifndef SYNTH
    a_flush_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !r_s1_ctl.is_pixel) |-> r_s1_ctl.emit)
        else $error("flush entered pipe without a result");

    a_blur_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_ctl.blur) |-> (r_s1_ctl.is_pixel && r_s1_ctl.emit))
        else $error("blur marked on a non-emitting or flush item");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_ctl.emit && r_m_valid && !i_m_ready)
            |=> (r_s1_valid && $stable(r_s1_addr)))
        else $error("input stage lost an item during output stall");
`endif

endmodule

// File: rtl/box_blur_3x3_rgb.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb
// Result path: the item that completes a result passes the stage-1 register,
//   then the output register; a pixel's result is completed by the pixel
//   image_width + 1 positions later, or by a flush transaction.
// Throughput: one transaction per cycle unless the output stalls, set by the
//   line store read at accept and write-back in stage 1 (write-first bypass).
// Reset: synchronous, active low; counters, window and valids clear, geometry
//   returns to 640 x 480. Line stores are not cleared and need no pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Pipeline:
//   accept  - bb3_ctrl decides result kind, source address and frame_end
//             from the counters; the line store read is launched.
//   stage 1 - line store data, window and input pixel form the 3x3
//             neighborhood; nine-tap sum, divide by nine via reciprocal,
//             line store write-back and window shift.
//   output  - registered result on m_axis; a new transaction is taken while
//             a result waits, as long as the stage-1 item can move on.
// Border pixels and flushed pixels come out unchanged. Flushes with nothing
// pending are taken and dropped.

module box_blur_3x3_rgb import bb3_pkg::*; #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,

    // pixel stream in
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [PIX_W-1:0]      s_axis_tdata,   // red_in, green_in, blue_in
    input  logic                  s_axis_tuser,   // operation (1 = flush)

    // pixel stream out
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [PIX_W-1:0]      m_axis_tdata,   // red_out, green_out, blue_out
    output logic                  m_axis_tlast    // frame_end
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic          s_ready;
    logic          accept;
    t_item_ctl     item_ctl;
    logic [CW-1:0] item_addr;

    // a transaction is taken when the stage-1 slot is free or moving on
    assign accept        = s_axis_tvalid && s_ready;
    assign s_axis_tready = s_ready;

    bb3_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_is_flush  (s_axis_tuser),
        .o_ctl       (item_ctl),
        .o_addr      (item_addr)
    );

    bb3_datapath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .o_s_ready (s_ready),
        .i_s_data  (s_axis_tdata),
        .i_ctl     (item_ctl),
        .i_addr    (item_addr),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_m_data  (m_axis_tdata),
        .o_m_last  (m_axis_tlast)
    );

endmodule
